FILE: sv/mqe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_pkg: shared definitions for the multi-queue with expedite
// Sizes, field widths, result codes and the access record that passes from
// the queue control to the top level.
// ----------------------------------------------------------------------------
package mqe_pkg;

   localparam int NUM_QUEUES  = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int TAG_WIDTH   = 16;

   localparam int KIND_W   = 1;
   localparam int QINDEX_W = 4;
   localparam int TAG_W    = 16;
   localparam int FILL_W   = 4;

   localparam int STORED_TAG_W = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;
   localparam int ENTRY_W      = STORED_TAG_W + 1;
   localparam int SLOT_COUNT   = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int QSEL_W       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEN_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      OUT_ENQUEUED = 2'd0,
      OUT_FULL     = 2'd1,
      OUT_DEQUEUED = 2'd2,
      OUT_EMPTY    = 2'd3
   } outcome_type;

   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [ADDR_W-1:0]    addr;
      logic [ENTRY_W-1:0]   wdata;
      outcome_type          outcome;
      logic [FILL_W-1:0]    fill;
   } access_type;

endpackage
`default_nettype wire

FILE: sv/mqe_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqe channel interfaces
// Valid/ready channels for operation requests and their responses.
// ----------------------------------------------------------------------------
interface mqe_req_if;
   import mqe_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [QINDEX_W-1:0] queue_index;
   logic                urgent;
   logic [TAG_W-1:0]    tag;

   modport source (output valid, output kind, output queue_index, output urgent,
                   output tag, input ready);
   modport sink   (input valid, input kind, input queue_index, input urgent,
                   input tag, output ready);
endinterface

interface mqe_rsp_if;
   import mqe_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        outcome;
   logic [TAG_W-1:0]  served_tag;
   logic              served_urgent;
   logic [FILL_W-1:0] queue_fill;

   modport source (output valid, output outcome, output served_tag,
                   output served_urgent, output queue_fill, input ready);
   modport sink   (input valid, input outcome, input served_tag,
                   input served_urgent, input queue_fill, output ready);
endinterface
`default_nettype wire

FILE: sv/mqe_entry_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_entry_ram: generic single-port synchronous RAM
// One write or one read per cycle; read data is registered and holds until
// the next read.
// ----------------------------------------------------------------------------
module mqe_entry_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 17
) (
   input  wire logic                                     clock,
   input  wire logic                                     we,
   input  wire logic                                     re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                         wdata,
   output      logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: sv/mqe_queue_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqe_queue_ctrl: per-queue head and length bookkeeping
// Decodes one operation against the addressed queue, picks the entry slot,
// produces the RAM access and result code, and updates head and length.
// ----------------------------------------------------------------------------
module mqe_queue_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [mqe_pkg::KIND_W-1:0]    kind,
   input  wire logic [mqe_pkg::QINDEX_W-1:0]  queue_index,
   input  wire logic                          urgent,
   input  wire logic [mqe_pkg::TAG_W-1:0]     tag,
   output      mqe_pkg::access_type           access
);
   import mqe_pkg::*;

   localparam int SUM_W = LEN_W + 1;

   logic [LEN_W-1:0] len_ff  [NUM_QUEUES];
   logic [PTR_W-1:0] head_ff [NUM_QUEUES];

   logic [QSEL_W-1:0] qsel;
   logic              in_range;
   logic [LEN_W-1:0]  len_cur;
   logic [PTR_W-1:0]  head_cur;
   logic [LEN_W-1:0]  len_in;
   logic [PTR_W-1:0]  head_in;
   logic [PTR_W-1:0]  slot;
   logic [SUM_W-1:0]  tail_sum;
   logic              update;

   assign in_range = 32'(queue_index) < NUM_QUEUES;
   assign qsel     = QSEL_W'(queue_index);
   assign len_cur  = len_ff[qsel];
   assign head_cur = head_ff[qsel];
   assign tail_sum = SUM_W'(head_cur) + SUM_W'(len_cur);

   always_comb begin
      len_in         = len_cur;
      head_in        = head_cur;
      slot           = head_cur;
      update         = 1'b0;
      access.we      = 1'b0;
      access.re      = 1'b0;
      access.wdata   = {urgent, tag[STORED_TAG_W-1:0]};
      access.outcome = OUT_FULL;
      access.fill    = '0;
      case (kind)
         KIND_ENQUEUE: begin
            if (!in_range) begin
               access.outcome = OUT_FULL;
            end else if (len_cur >= LEN_W'(QUEUE_DEPTH)) begin
               access.outcome = OUT_FULL;
               access.fill    = FILL_W'(len_cur);
            end else begin
               if (urgent) begin
                  slot    = (head_cur == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_cur - 1'b1;
                  head_in = slot;
               end else if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
                  slot = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
               end else begin
                  slot = PTR_W'(tail_sum);
               end
               len_in         = len_cur + 1'b1;
               update         = 1'b1;
               access.we      = 1'b1;
               access.outcome = OUT_ENQUEUED;
               access.fill    = FILL_W'(len_in);
            end
         end
         default: begin
            if (!in_range || len_cur == '0) begin
               access.outcome = OUT_EMPTY;
            end else begin
               slot           = head_cur;
               head_in        = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
               len_in         = len_cur - 1'b1;
               update         = 1'b1;
               access.re      = 1'b1;
               access.outcome = OUT_DEQUEUED;
               access.fill    = FILL_W'(len_in);
            end
         end
      endcase
      access.addr = ADDR_W'(int'(qsel) * QUEUE_DEPTH + int'(slot));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            len_ff[i]  <= '0;
            head_ff[i] <= '0;
         end
      end else if (accept && update) begin
         len_ff[qsel]  <= len_in;
         head_ff[qsel] <= head_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/multi_queue_with_expedite.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_with_expedite: bounded queues with head insertion of urgent items
// Sixteen ring-buffer queues of eight entries share one entry RAM; head and
// length of each queue live in registers.
// ----------------------------------------------------------------------------
// The block accepts one item per cycle unless a stalled response backs it
// up, and answers each with one response item, in order, through a middle
// stage and an output register. An item is decoded against its queue's head
// and length when accepted, which also writes the entry RAM for an enqueue or
// starts its registered read for a dequeue. A stalled response holds one
// further item in the middle stage before the request side stops. Entries
// need no clearing after reset, since only written entries are read.
module multi_queue_with_expedite (
   input wire logic clock,
   input wire logic reset,
   mqe_req_if.sink  req_chan,
   mqe_rsp_if.source rsp_chan
);
   import mqe_pkg::*;

   access_type         access;
   logic               accept;
   logic               s1_advance;
   logic [ENTRY_W-1:0] rdata;

   logic               s1_valid_ff;
   outcome_type        s1_outcome_ff;
   logic [FILL_W-1:0]  s1_fill_ff;

   logic               out_valid_ff;
   logic [1:0]         out_outcome_ff;
   logic [TAG_W-1:0]   out_tag_ff;
   logic               out_urgent_ff;
   logic [FILL_W-1:0]  out_fill_ff;

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   mqe_queue_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_chan.kind),
      .queue_index (req_chan.queue_index),
      .urgent      (req_chan.urgent),
      .tag         (req_chan.tag),
      .access      (access)
   );

   mqe_entry_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock (clock),
      .we    (accept && access.we),
      .re    (accept && access.re),
      .addr  (access.addr),
      .wdata (access.wdata),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_outcome_ff <= access.outcome;
         s1_fill_ff    <= access.fill;
      end
      if (s1_advance) begin
         out_outcome_ff <= s1_outcome_ff;
         out_fill_ff    <= s1_fill_ff;
         if (s1_outcome_ff == OUT_DEQUEUED) begin
            out_tag_ff    <= TAG_W'(rdata[STORED_TAG_W-1:0]);
            out_urgent_ff <= rdata[ENTRY_W-1];
         end else begin
            out_tag_ff    <= '0;
            out_urgent_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.outcome       = out_outcome_ff;
   assign rsp_chan.served_tag    = out_tag_ff;
   assign rsp_chan.served_urgent = out_urgent_ff;
   assign rsp_chan.queue_fill    = out_fill_ff;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multi-queue with expedite
// A driver feeds queue operations over the request channel. Every accepted
// item is applied to a local model of the sixteen queues, and the response
// it predicts is queued. A monitor checks each response item against the
// oldest prediction, field by field. Phases vary the sender and receiver
// idling, and one phase holds the receiver off long enough to back up the
// request side.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mqe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 100;
   localparam int SETTLE_CYCLES  = 8;
   localparam int SEGMENT_LEN    = 16;

   typedef enum logic [2:0] {
      FLOW_STEADY,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH_IDLE,
      FLOW_PRESSURE
   } flow_mode_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [QINDEX_W-1:0] queue_index;
      logic                urgent;
      logic [TAG_W-1:0]    tag;
   } queue_op_type;

   typedef struct packed {
      outcome_type       outcome;
      logic [TAG_W-1:0]  served_tag;
      logic              served_urgent;
      logic [FILL_W-1:0] queue_fill;
   } queue_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mqe_req_if req_bus ();
   mqe_rsp_if rsp_bus ();

   multi_queue_with_expedite i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   flow_mode_type flow = FLOW_STEADY;

   queue_op_type  ops_pending[$];
   queue_rsp_type responses_due[$];
   queue_op_type  op_on_bus;

   logic [STORED_TAG_W-1:0] slot_tag    [NUM_QUEUES][QUEUE_DEPTH];
   logic                    slot_urgent [NUM_QUEUES][QUEUE_DEPTH];
   int unsigned             queue_len   [NUM_QUEUES];
   int unsigned             queue_head  [NUM_QUEUES];

   int error_count = 0;
   int idle_cycles = 0;
   int hold_count  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_ENQUEUE;
      req_bus.queue_index = '0;
      req_bus.urgent      = 1'b0;
      req_bus.tag         = '0;
      rsp_bus.ready       = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic queue_rsp_type apply_queue_op(input queue_op_type op);
      queue_rsp_type rsp;
      int unsigned   qi;
      int unsigned   len;
      int unsigned   head;
      int unsigned   slot;
      rsp = '{outcome: OUT_EMPTY, served_tag: '0, served_urgent: 1'b0, queue_fill: '0};
      if (int'(op.queue_index) >= NUM_QUEUES) begin
         rsp.outcome = (op.kind == KIND_DEQUEUE) ? OUT_EMPTY : OUT_FULL;
         return rsp;
      end
      qi   = op.queue_index;
      len  = queue_len[qi];
      head = queue_head[qi];
      if (op.kind == KIND_ENQUEUE) begin
         if (len >= QUEUE_DEPTH) begin
            rsp.outcome = OUT_FULL;
         end else begin
            if (op.urgent) begin
               head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               slot = head;
               queue_head[qi] = head;
            end else begin
               slot = (head + len) % QUEUE_DEPTH;
            end
            slot_tag[qi][slot]    = op.tag[STORED_TAG_W-1:0];
            slot_urgent[qi][slot] = op.urgent;
            len++;
            queue_len[qi] = len;
            rsp.outcome = OUT_ENQUEUED;
         end
      end else begin
         if (len == 0) begin
            rsp.outcome = OUT_EMPTY;
         end else begin
            slot = head % QUEUE_DEPTH;
            rsp.served_tag    = TAG_W'(slot_tag[qi][slot]);
            rsp.served_urgent = slot_urgent[qi][slot];
            queue_head[qi] = (slot + 1) % QUEUE_DEPTH;
            len--;
            queue_len[qi] = len;
            rsp.outcome = OUT_DEQUEUED;
         end
      end
      rsp.queue_fill = FILL_W'(len);
      return rsp;
   endfunction

   function automatic bit sender_rests();
      case (flow)
         FLOW_SENDER_IDLE: return $urandom_range(0, 99) < 69;
         FLOW_BOTH_IDLE:   return $urandom_range(0, 99) < 7;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (flow)
         FLOW_RECEIVER_STALL: return $urandom_range(0, 99) < 69;
         FLOW_BOTH_IDLE:      return $urandom_range(0, 99) < 7;
         default:             return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            responses_due.push_back(apply_queue_op(op_on_bus));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (ops_pending.size() != 0 && !sender_rests()) begin
               op_on_bus = ops_pending.pop_front();
               req_bus.kind        <= op_on_bus.kind;
               req_bus.queue_index <= op_on_bus.queue_index;
               req_bus.urgent      <= op_on_bus.urgent;
               req_bus.tag         <= op_on_bus.tag;
               req_bus.valid       <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      queue_rsp_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (responses_due.size() == 0) begin
               report_mismatch($sformatf("response item with none expected, outcome %0d",
                                         rsp_bus.outcome));
            end else begin
               due = responses_due.pop_front();
               if (rsp_bus.outcome !== due.outcome)
                  report_mismatch($sformatf("outcome %0d, expected %0d",
                                            rsp_bus.outcome, due.outcome));
               if (rsp_bus.served_tag !== due.served_tag)
                  report_mismatch($sformatf("served_tag %h, expected %h",
                                            rsp_bus.served_tag, due.served_tag));
               if (rsp_bus.served_urgent !== due.served_urgent)
                  report_mismatch($sformatf("served_urgent %b, expected %b",
                                            rsp_bus.served_urgent, due.served_urgent));
               if (rsp_bus.queue_fill !== due.queue_fill)
                  report_mismatch($sformatf("queue_fill %0d, expected %0d",
                                            rsp_bus.queue_fill, due.queue_fill));
            end
         end
         if (flow == FLOW_PRESSURE && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !receiver_stalls();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR at %0t: no item moved for %0d cycles", $realtime, idle_cycles);
         $display("multi_queue_with_expedite verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_op(input logic [KIND_W-1:0] kind, input int queue_index,
                          input logic urgent, input logic [TAG_W-1:0] tag);
      queue_op_type op;
      op.kind        = kind;
      op.queue_index = QINDEX_W'(queue_index);
      op.urgent      = urgent;
      op.tag         = tag;
      ops_pending.push_back(op);
   endtask

   task automatic push_random_ops(input int count);
      int hot_queue;
      int enqueue_pct;
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            hot_queue   = $urandom_range(0, NUM_QUEUES - 1);
            enqueue_pct = ((n / SEGMENT_LEN) % 2 == 0) ? 75 : 25;
         end
         pick = ($urandom_range(0, 99) < 80) ? hot_queue : $urandom_range(0, NUM_QUEUES - 1);
         push_op(($urandom_range(0, 99) < enqueue_pct) ? KIND_ENQUEUE : KIND_DEQUEUE, pick,
                 1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 65535)));
      end
   endtask

   task automatic drain();
      while (ops_pending.size() != 0 || req_bus.valid || responses_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
         queue_len[q]  = 0;
         queue_head[q] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill the last queue with mixed urgency, overflow it, then empty it
      // with dequeue items whose urgent bit and tag must be ignored.
      push_op(KIND_ENQUEUE, 15, 1'b0, 16'h0000);
      push_op(KIND_ENQUEUE, 15, 1'b1, 16'hFFFF);
      push_op(KIND_ENQUEUE, 15, 1'b0, 16'h1234);
      push_op(KIND_ENQUEUE, 15, 1'b1, 16'h8001);
      push_op(KIND_ENQUEUE, 15, 1'b0, 16'h7FFE);
      push_op(KIND_ENQUEUE, 15, 1'b0, 16'h00FF);
      push_op(KIND_ENQUEUE, 15, 1'b1, 16'hFF00);
      push_op(KIND_ENQUEUE, 15, 1'b0, 16'h5A5A);
      push_op(KIND_ENQUEUE, 15, 1'b1, 16'h4321);
      for (int n = 0; n < QUEUE_DEPTH + 1; n++)
         push_op(KIND_DEQUEUE, 15, 1'(n % 2), (n % 2) ? 16'hFFFF : 16'h0000);
      push_op(KIND_ENQUEUE, 0, 1'b1, 16'hAAAA);
      push_op(KIND_DEQUEUE, 0, 1'b1, 16'h5555);
      push_op(KIND_DEQUEUE, 0, 1'b0, 16'h0000);
      drain();

      push_random_ops(230);
      drain();
      flow = FLOW_SENDER_IDLE;
      push_random_ops(230);
      drain();
      flow = FLOW_RECEIVER_STALL;
      push_random_ops(230);
      drain();
      flow = FLOW_BOTH_IDLE;
      push_random_ops(200);
      drain();
      flow = FLOW_PRESSURE;
      push_random_ops(40);
      drain();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("multi_queue_with_expedite verification clean");
      end else begin
         $display("multi_queue_with_expedite verification failed");
      end
      $finish;
   end

endmodule
